### design/assert_macros.svh
// Assertion macros used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### design/isotp_rx_pkg.sv
// Types and constants of the ISO-TP receive reassembler
`default_nettype none

package isotp_rx_pkg;

  localparam int unsigned ID_W       = 29;
  localparam int unsigned CFG_DATA_W = 29;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned LEN_W      = 12;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned SEQ_W      = 4;
  localparam int unsigned JOB_BYTES  = 7;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_RECEIVE_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_TIME   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 2'd3;

  localparam logic [MS_W-1:0]  TIMEOUT_RESET = 16'd1000;
  localparam logic [MS_W-1:0]  MS_SAT        = 16'hFFFF;
  localparam logic [7:0]       FC_CTS        = 8'h30;
  localparam logic [3:0]       SF_MAX        = 4'd7;
  localparam logic [LEN_W-1:0] FF_DATA       = 12'd6;
  localparam logic [LEN_W-1:0] CF_DATA       = 12'd7;
  localparam logic [SEQ_W-1:0] SEQ_FIRST     = 4'd1;

  localparam logic [3:0] PCI_SF = 4'd0;
  localparam logic [3:0] PCI_FF = 4'd1;
  localparam logic [3:0] PCI_CF = 4'd2;

  typedef enum logic [2:0] {
    KIND_DATA    = 3'd0,
    KIND_FLOW    = 3'd1,
    KIND_EMPTY   = 3'd2,
    KIND_BADTYPE = 3'd3,
    KIND_SEQERR  = 3'd4,
    KIND_FOREIGN = 3'd5,
    KIND_TIMEOUT = 3'd6
  } kind_e;

  typedef struct packed {
    logic            mode;
    logic [ID_W-1:0] frame_id;
    logic [7:0][7:0] bytes;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0] receive_id;
    logic [7:0]      flow_bs;
    logic [7:0]      sep_time;
    logic [MS_W-1:0] tmo_ms;
  } cfg_t;

  // one classified request: optional leading status, data bytes, optional flow control
  typedef struct packed {
    logic                      lead;
    kind_e                     lead_kind;
    logic [JOB_BYTES-1:0][7:0] data;
    logic [2:0]                count;
    logic                      last_final;
    logic                      flow;
    logic [7:0]                fc_bs;
    logic [7:0]                fc_st;
  } job_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic       last;
    logic [7:0] control_byte1;
    logic [7:0] control_byte2;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

### design/isotp_rx_front.sv
// Front end: accepts requests, tracks message state and classifies into jobs
`default_nettype none

module isotp_rx_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  isotp_rx_pkg::item_t  item_i,
  input  isotp_rx_pkg::cfg_t   cfg_i,
  input  isotp_rx_pkg::q_stat_t q_stat_i,
  output logic                 push_o,
  output isotp_rx_pkg::job_t   job_o
);

  logic                            receiving_q, receiving_d;
  logic [isotp_rx_pkg::SEQ_W-1:0]  seq_q, seq_d;
  logic [isotp_rx_pkg::LEN_W-1:0]  rem_q, rem_d;
  logic [isotp_rx_pkg::MS_W-1:0]   elapsed_q, elapsed_d;

  logic                            accept;
  logic [3:0]                      pci;
  logic [3:0]                      low;
  logic [isotp_rx_pkg::LEN_W-1:0]  total;
  logic [isotp_rx_pkg::LEN_W-1:0]  cf_count;
  logic [isotp_rx_pkg::LEN_W-1:0]  rem_next;
  logic [isotp_rx_pkg::MS_W-1:0]   elapsed_inc;
  logic                            id_match;

  assign in_ready_o  = !q_stat_i.full;
  assign accept      = in_valid_i && in_ready_o;
  assign pci         = item_i.bytes[0][7:4];
  assign low         = item_i.bytes[0][3:0];
  assign total       = {low, item_i.bytes[1]};
  assign id_match    = (item_i.frame_id == cfg_i.receive_id);
  assign cf_count    = (rem_q < isotp_rx_pkg::CF_DATA) ? rem_q : isotp_rx_pkg::CF_DATA;
  assign rem_next    = rem_q - cf_count;
  assign elapsed_inc = (elapsed_q != isotp_rx_pkg::MS_SAT) ? elapsed_q + 16'd1 : elapsed_q;

  always_comb begin
    receiving_d = receiving_q;
    seq_d       = seq_q;
    rem_d       = rem_q;
    elapsed_d   = elapsed_q;
    push_o      = 1'b0;
    job_o       = '0;
    job_o.lead_kind = isotp_rx_pkg::KIND_DATA;
    job_o.fc_bs = cfg_i.flow_bs;
    job_o.fc_st = cfg_i.sep_time;
    job_o.data  = {item_i.bytes[7], item_i.bytes[6], item_i.bytes[5], item_i.bytes[4],
                   item_i.bytes[3], item_i.bytes[2], item_i.bytes[1]};
    if (accept) begin
      if (item_i.mode) begin
        if (receiving_q) begin
          if (elapsed_inc >= cfg_i.tmo_ms) begin
            push_o          = 1'b1;
            job_o.lead      = 1'b1;
            job_o.lead_kind = isotp_rx_pkg::KIND_TIMEOUT;
            receiving_d     = 1'b0;
            seq_d           = isotp_rx_pkg::SEQ_FIRST;
            rem_d           = '0;
            elapsed_d       = '0;
          end else begin
            elapsed_d = elapsed_inc;
          end
        end
      end else if (!receiving_q) begin
        if (id_match) begin
          push_o = 1'b1;
          unique case (pci)
            isotp_rx_pkg::PCI_SF: begin
              job_o.count      = (low > isotp_rx_pkg::SF_MAX) ? 3'd7 : low[2:0];
              job_o.lead       = (low == 4'd0);
              job_o.lead_kind  = isotp_rx_pkg::KIND_EMPTY;
              job_o.last_final = 1'b1;
            end
            isotp_rx_pkg::PCI_FF: begin
              job_o.data       = {8'h00, item_i.bytes[7], item_i.bytes[6], item_i.bytes[5],
                                  item_i.bytes[4], item_i.bytes[3], item_i.bytes[2]};
              job_o.count      = (total < isotp_rx_pkg::FF_DATA) ? total[2:0]
                                                                 : isotp_rx_pkg::FF_DATA[2:0];
              job_o.lead       = (total == '0);
              job_o.lead_kind  = isotp_rx_pkg::KIND_EMPTY;
              job_o.last_final = (total <= isotp_rx_pkg::FF_DATA);
              job_o.flow       = 1'b1;
              if (total > isotp_rx_pkg::FF_DATA) begin
                receiving_d = 1'b1;
                seq_d       = isotp_rx_pkg::SEQ_FIRST;
                rem_d       = total - isotp_rx_pkg::FF_DATA;
                elapsed_d   = '0;
              end
            end
            default: begin
              job_o.lead      = 1'b1;
              job_o.lead_kind = isotp_rx_pkg::KIND_BADTYPE;
            end
          endcase
        end
      end else begin
        push_o = 1'b1;
        if (!id_match || pci != isotp_rx_pkg::PCI_CF || low != seq_q) begin
          job_o.lead = 1'b1;
          if (!id_match) begin
            job_o.lead_kind = isotp_rx_pkg::KIND_FOREIGN;
          end else if (pci != isotp_rx_pkg::PCI_CF) begin
            job_o.lead_kind = isotp_rx_pkg::KIND_BADTYPE;
          end else begin
            job_o.lead_kind = isotp_rx_pkg::KIND_SEQERR;
          end
          receiving_d = 1'b0;
          seq_d       = isotp_rx_pkg::SEQ_FIRST;
          rem_d       = '0;
          elapsed_d   = '0;
        end else begin
          job_o.count      = cf_count[2:0];
          job_o.last_final = (rem_next == '0);
          seq_d            = seq_q + 4'd1;
          rem_d            = rem_next;
          if (rem_next == '0) begin
            receiving_d = 1'b0;
            seq_d       = isotp_rx_pkg::SEQ_FIRST;
            elapsed_d   = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q <= 1'b0;
      seq_q       <= isotp_rx_pkg::SEQ_FIRST;
      rem_q       <= '0;
      elapsed_q   <= '0;
    end else begin
      receiving_q <= receiving_d;
      seq_q       <= seq_d;
      rem_q       <= rem_d;
      elapsed_q   <= elapsed_d;
    end
  end

endmodule

`default_nettype wire

### design/isotp_rx_queue.sv
// Short job queue between front and back end
`default_nettype none

module isotp_rx_queue (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     push_i,
  input  isotp_rx_pkg::job_t      job_i,
  input  wire                     pop_i,
  output isotp_rx_pkg::job_t      head_o,
  output isotp_rx_pkg::q_stat_t   stat_o
);

  isotp_rx_pkg::job_t                entry_q [isotp_rx_pkg::QUEUE_DEPTH];
  logic [isotp_rx_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [isotp_rx_pkg::QCNT_W-1:0]   cnt_q, cnt_d;

  assign head_o       = entry_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == isotp_rx_pkg::QCNT_W'(isotp_rx_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == isotp_rx_pkg::QPTR_W'(isotp_rx_pkg::QUEUE_DEPTH - 1))
                    ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == isotp_rx_pkg::QPTR_W'(isotp_rx_pkg::QUEUE_DEPTH - 1))
                    ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### design/isotp_rx_back.sv
// Back end: serialises one job into result items through an output register
`default_nettype none

module isotp_rx_back (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  isotp_rx_pkg::job_t      head_i,
  input  isotp_rx_pkg::q_stat_t   q_stat_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  output isotp_rx_pkg::res_t      res_o
);

  logic [2:0]          pos_q;
  logic                out_valid_q;
  isotp_rx_pkg::res_t  res_q, res_d;
  logic                avail, adv, final_step;
  logic [3:0]          total;
  logic [2:0]          di;

  assign avail      = !q_stat_i.empty;
  assign adv        = !out_valid_q || out_ready_i;
  assign total      = {3'b000, head_i.lead} + {1'b0, head_i.count} + {3'b000, head_i.flow};
  assign final_step = ({1'b0, pos_q} == total - 4'd1);
  assign pop_o      = avail && adv && final_step;
  assign di         = pos_q - {2'b00, head_i.lead};

  always_comb begin
    res_d = '0;
    res_d.kind = isotp_rx_pkg::KIND_DATA;
    if (head_i.lead && pos_q == 3'd0) begin
      res_d.kind = head_i.lead_kind;
    end else if (di < head_i.count) begin
      res_d.data_byte = head_i.data[di];
      res_d.last      = head_i.last_final && (di == head_i.count - 3'd1);
    end else begin
      res_d.kind          = isotp_rx_pkg::KIND_FLOW;
      res_d.data_byte     = isotp_rx_pkg::FC_CTS;
      res_d.control_byte1 = head_i.fc_bs;
      res_d.control_byte2 = head_i.fc_st;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && avail) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pos_q       <= '0;
    end else begin
      if (adv) begin
        out_valid_q <= avail;
      end
      if (pop_o) begin
        pos_q <= '0;
      end else if (adv && avail) begin
        pos_q <= pos_q + 3'd1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

### design/iso_tp_receive_reassembler.sv
// Top level of the ISO-TP receive reassembler
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------------
//  input    | in_valid_i / in_ready_o  | mode_i, frame_id_i, byte0_i .. byte7_i
//  result   | out_valid_o / out_ready_i| kind_o, data_byte_o, last_o, control_byte*_o
//  config   | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// A request is classified in the cycle it is taken; a frame yields 0 to 7 results,
// one per cycle from the back end while out_ready_i is high.
// A two-entry job queue lets the front take requests while the back end is stalled.
// Reset clears message state, queue pointers and output valid; config registers take defaults.
`default_nettype none
`include "assert_macros.svh"

module iso_tp_receive_reassembler (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire [isotp_rx_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire [isotp_rx_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  wire                                  mode_i,
  input  wire [isotp_rx_pkg::ID_W-1:0]         frame_id_i,
  input  wire [7:0]                            byte0_i,
  input  wire [7:0]                            byte1_i,
  input  wire [7:0]                            byte2_i,
  input  wire [7:0]                            byte3_i,
  input  wire [7:0]                            byte4_i,
  input  wire [7:0]                            byte5_i,
  input  wire [7:0]                            byte6_i,
  input  wire [7:0]                            byte7_i,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output logic [2:0]                           kind_o,
  output logic [7:0]                           data_byte_o,
  output logic                                 last_o,
  output logic [7:0]                           control_byte1_o,
  output logic [7:0]                           control_byte2_o
);

  isotp_rx_pkg::cfg_t    cfg_q;
  isotp_rx_pkg::item_t   item;
  isotp_rx_pkg::job_t    job, head;
  isotp_rx_pkg::q_stat_t q_stat;
  isotp_rx_pkg::res_t    res;
  logic                  push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.receive_id <= '0;
      cfg_q.flow_bs    <= '0;
      cfg_q.sep_time   <= '0;
      cfg_q.tmo_ms     <= isotp_rx_pkg::TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        isotp_rx_pkg::REG_RECEIVE_ID: cfg_q.receive_id <= cfg_wdata_i;
        isotp_rx_pkg::REG_BLOCK_SIZE: cfg_q.flow_bs    <= cfg_wdata_i[7:0];
        isotp_rx_pkg::REG_SEP_TIME:   cfg_q.sep_time   <= cfg_wdata_i[7:0];
        isotp_rx_pkg::REG_TIMEOUT:    cfg_q.tmo_ms     <= cfg_wdata_i[isotp_rx_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

  assign item.mode     = mode_i;
  assign item.frame_id = frame_id_i;
  assign item.bytes    = {byte7_i, byte6_i, byte5_i, byte4_i,
                          byte3_i, byte2_i, byte1_i, byte0_i};

  isotp_rx_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (item),
    .cfg_i      (cfg_q),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .job_o      (job)
  );

  isotp_rx_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  isotp_rx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign kind_o          = res.kind;
  assign data_byte_o     = res.data_byte;
  assign last_o          = res.last;
  assign control_byte1_o = res.control_byte1;
  assign control_byte2_o = res.control_byte2;

  `ASSERT_NEVER(a_push_when_full, push && q_stat.full, "job pushed into full queue")
  `ASSERT_NEVER(a_pop_when_empty, pop && q_stat.empty, "job popped from empty queue")
  `ASSERT_CLK(a_last_is_data, out_valid_o && last_o |-> kind_o == isotp_rx_pkg::KIND_DATA,
              "last flag on a non-data result")

endmodule

`default_nettype wire
